[rtl/huf_pkg.sv]
// Shared types and constants for the static Huffman table builder and encoder.
// Used by huf_if, huf_dp, huf_ctrl and the top level; depends on nothing.
package huf_pkg;

  localparam int ALPHA    = 256;             // byte alphabet
  localparam int SYM_W    = 8;
  localparam int COUNT_W  = 32;              // histogram counter width
  localparam int WEIGHT_W = 40;              // node weight, holds a full sum
  localparam int NODE_N   = 2 * ALPHA - 1;   // leaves plus merged nodes
  localparam int NODE_W   = 9;               // node index width
  localparam int CODE_W   = 48;              // code field width
  localparam int LEN_W    = 6;
  localparam int MAX_CODE_LEN = 48;
  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  localparam logic [NODE_W-1:0] NO_NODE = '1;
  localparam logic [NODE_W-1:0] ALPHA_N = NODE_W'(ALPHA);

  typedef enum logic [1:0] {
    REQ_COUNT  = 2'd0,
    REQ_BUILD  = 2'd1,
    REQ_ENCODE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ABSENT = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_SAT    = 3'd3,
    ST_LONG   = 3'd4
  } status_t;

  // One entry of the node store.
  typedef struct packed {
    logic                live;
    logic [WEIGHT_W-1:0] weight;
    logic [NODE_W-1:0]   parent;
    logic                branch;
  } node_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic cnt_upd;
    logic enc_eval;
    logic clr;
    logic bi_start;
    logic bi_step;
    logic sc_start;
    logic sc_step;
    logic mg_new;
    logic mg_a;
    logic mg_b;
    logic cd_start;
    logic cd_chk;
    logic w_rd;
    logic w_up;
    logic c_wr;
    logic c_next;
    logic res_empty;
    logic res_long;
    logic res_built;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bi_done;
    logic pres_zero;
    logic pres_one;
    logic pres_two;
    logic sc_done;
    logic chk_present;
    logic at_root;
    logic too_long;
    logic last_sym;
  } sts_t;

endpackage

[rtl/huf_if.sv]
// Handshake channels of the Huffman block: request words in, result words out.
// Depends on huf_pkg for field widths.
interface huf_in_if import huf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, req_type, symbol, input ready);
  modport sink   (input valid, req_type, symbol, output ready);
endinterface

interface huf_out_if import huf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;

  modport source (output valid, status, code_bits, code_length, input ready);
  modport sink   (input valid, status, code_bits, code_length, output ready);
endinterface

[rtl/huf_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module huf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/huf_dp.sv]
// Datapath of the Huffman block: histogram, node store, code table and result.
// Depends on huf_pkg and huf_ram.
module huf_dp import huf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [1:0]        in_req_type,
  input  logic [SYM_W-1:0]  in_symbol,
  output sts_t              sts,
  output logic [2:0]        out_status,
  output logic [CODE_W-1:0] out_code_bits,
  output logic [LEN_W-1:0]  out_code_length
);

  logic [ALPHA-1:0]    vld_r;
  logic                hvld_r;
  logic                sat_r;
  logic                tv_r;
  logic [SYM_W-1:0]    sym_r;
  logic [NODE_W-1:0]   k_r;
  logic [NODE_W-1:0]   i_r;
  logic [NODE_W-1:0]   next_r;
  logic [NODE_W-1:0]   present_r;
  logic [NODE_W-1:0]   root_r;
  logic [WEIGHT_W-1:0] w1_r, w2_r;
  logic [NODE_W-1:0]   i1_r, i2_r;
  logic                h1_r, h2_r;
  logic [NODE_W-1:0]   node_r;
  logic [LEN_W-1:0]    len_r;
  logic [CODE_W-1:0]   code_r;
  logic [2:0]          res_status_r;
  logic [CODE_W-1:0]   res_code_r;
  logic [LEN_W-1:0]    res_len_r;
  logic [2:0]          out_status_r;
  logic [CODE_W-1:0]   out_code_r;
  logic [LEN_W-1:0]    out_len_r;

  logic [SYM_W-1:0]        hist_raddr;
  logic [COUNT_W-1:0]      hist_rdata;
  logic [COUNT_W-1:0]      eff;
  logic                    node_we;
  logic [NODE_W-1:0]       node_waddr;
  node_t                   node_wdata;
  logic [NODE_W-1:0]       node_raddr;
  logic [$bits(node_t)-1:0] node_rword;
  node_t                   nd;
  logic [CODE_W+LEN_W-1:0] ct_rdata;

  // Histogram store; entries without a valid bit read as zero.
  assign hist_raddr = cmd.accept ? in_symbol : k_r[SYM_W-1:0];
  assign eff        = hvld_r ? hist_rdata : '0;

  huf_ram #(.WIDTH(COUNT_W), .DEPTH(ALPHA)) u_hist (
    .clk   (clk),
    .we    (cmd.cnt_upd && (eff != '1)),
    .waddr (sym_r),
    .wdata (eff + COUNT_W'(1)),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // Node store write select: leaf load, new merged node, or child update.
  always_comb begin
    node_we    = 1'b0;
    node_waddr = k_r - NODE_W'(1);
    node_wdata = '{live: 1'b0, weight: '0, parent: NO_NODE, branch: 1'b0};
    if (cmd.bi_step && (k_r != '0)) begin
      node_we           = 1'b1;
      node_wdata.live   = (eff != '0);
      node_wdata.weight = {{(WEIGHT_W-COUNT_W){1'b0}}, eff};
    end else if (cmd.mg_new) begin
      node_we           = 1'b1;
      node_waddr        = next_r;
      node_wdata.live   = 1'b1;
      node_wdata.weight = w1_r + w2_r;
    end else if (cmd.mg_a) begin
      node_we           = 1'b1;
      node_waddr        = i1_r;
      node_wdata.parent = next_r;
    end else if (cmd.mg_b) begin
      node_we           = 1'b1;
      node_waddr        = i2_r;
      node_wdata.parent = next_r;
      node_wdata.branch = 1'b1;
    end
  end

  assign node_raddr = cmd.w_rd ? node_r : i_r;

  huf_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_N)) u_node (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rword)
  );

  assign nd = node_t'(node_rword);

  // Code table, read at the incoming symbol for encode words.
  huf_ram #(.WIDTH(CODE_W+LEN_W), .DEPTH(ALPHA)) u_code (
    .clk   (clk),
    .we    (cmd.c_wr),
    .waddr (k_r[SYM_W-1:0]),
    .wdata ({code_r, len_r}),
    .raddr (in_symbol),
    .rdata (ct_rdata)
  );

  // Control state: valid bits, flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      sat_r  <= 1'b0;
      tv_r   <= 1'b0;
    end else begin
      if (cmd.clr) begin
        vld_r <= '0;
        sat_r <= 1'b0;
        tv_r  <= 1'b0;
      end
      if (cmd.cnt_upd) begin
        tv_r <= 1'b0;
        if (eff == '1) begin
          sat_r <= 1'b1;
        end else begin
          vld_r[sym_r] <= 1'b1;
        end
      end
      if (cmd.bi_start || cmd.res_long) begin
        tv_r <= 1'b0;
      end
      if (cmd.res_built) begin
        tv_r <= 1'b1;
      end
    end
  end

  // Build counters, min tracking, code walk and result registers.
  always_ff @(posedge clk) begin
    hvld_r <= vld_r[hist_raddr];
    if (cmd.accept) begin
      sym_r <= in_symbol;
      if (in_req_type == REQ_CLEAR) begin
        res_status_r <= ST_OK;
        res_code_r   <= '0;
        res_len_r    <= '0;
      end
    end
    if (cmd.cnt_upd) begin
      res_status_r <= (eff == '1) ? ST_SAT : ST_OK;
      res_code_r   <= '0;
      res_len_r    <= '0;
    end
    if (cmd.enc_eval) begin
      if (!tv_r) begin
        res_status_r <= ST_EMPTY;
        res_code_r   <= '0;
        res_len_r    <= '0;
      end else if (eff == '0) begin
        res_status_r <= ST_ABSENT;
        res_code_r   <= '0;
        res_len_r    <= '0;
      end else begin
        res_status_r <= ST_OK;
        res_code_r   <= ct_rdata[CODE_W+LEN_W-1:LEN_W];
        res_len_r    <= ct_rdata[LEN_W-1:0];
      end
    end
    if (cmd.bi_start) begin
      k_r       <= '0;
      present_r <= '0;
      next_r    <= ALPHA_N;
    end
    if (cmd.bi_step) begin
      k_r <= k_r + NODE_W'(1);
      if ((k_r != '0) && (eff != '0)) begin
        present_r <= present_r + NODE_W'(1);
        root_r    <= k_r - NODE_W'(1);
      end
    end
    if (cmd.sc_start) begin
      i_r  <= '0;
      h1_r <= 1'b0;
      h2_r <= 1'b0;
    end
    if (cmd.sc_step) begin
      if (i_r != next_r) begin
        i_r <= i_r + NODE_W'(1);
      end
      if ((i_r != '0) && nd.live) begin
        if (!h1_r || (nd.weight < w1_r)) begin
          w2_r <= w1_r;
          i2_r <= i1_r;
          h2_r <= h1_r;
          w1_r <= nd.weight;
          i1_r <= i_r - NODE_W'(1);
          h1_r <= 1'b1;
        end else if (!h2_r || (nd.weight < w2_r)) begin
          w2_r <= nd.weight;
          i2_r <= i_r - NODE_W'(1);
          h2_r <= 1'b1;
        end
      end
    end
    if (cmd.mg_b) begin
      root_r    <= next_r;
      next_r    <= next_r + NODE_W'(1);
      present_r <= present_r - NODE_W'(1);
    end
    if (cmd.cd_start) begin
      k_r <= '0;
    end
    if (cmd.cd_chk) begin
      node_r <= k_r;
      len_r  <= '0;
      code_r <= '0;
    end
    if (cmd.w_up) begin
      if (nd.branch && (len_r < LEN_W'(CODE_W))) begin
        code_r[len_r] <= 1'b1;
      end
      len_r  <= len_r + LEN_W'(1);
      node_r <= nd.parent;
    end
    if (cmd.c_next) begin
      k_r <= k_r + NODE_W'(1);
    end
    if (cmd.res_empty || cmd.res_long || cmd.res_built) begin
      res_code_r <= '0;
      res_len_r  <= '0;
      if (cmd.res_empty) begin
        res_status_r <= ST_EMPTY;
      end else if (cmd.res_long) begin
        res_status_r <= ST_LONG;
      end else begin
        res_status_r <= sat_r ? ST_SAT : ST_OK;
      end
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_code_r   <= res_code_r;
      out_len_r    <= res_len_r;
    end
  end

  // Status toward the controller.
  assign sts.bi_done     = (k_r == ALPHA_N);
  assign sts.pres_zero   = (present_r == '0);
  assign sts.pres_one    = (present_r == NODE_W'(1));
  assign sts.pres_two    = (present_r == NODE_W'(2));
  assign sts.sc_done     = (i_r == next_r);
  assign sts.chk_present = (eff != '0);
  assign sts.at_root     = (node_r == root_r);
  assign sts.too_long    = (len_r == LEN_W'(LEN_LIMIT));
  assign sts.last_sym    = (k_r == ALPHA_N - NODE_W'(1));

  assign out_status      = out_status_r;
  assign out_code_bits   = out_code_r;
  assign out_code_length = out_len_r;

endmodule

[rtl/huf_ctrl.sv]
// Controller of the Huffman block: sequences count, encode, clear and build.
// Depends on huf_pkg; drives the datapath through cmd_t, reads sts_t.
module huf_ctrl import huf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_CNT   = 15'h0002,
    S_ENC   = 15'h0004,
    S_BINIT = 15'h0008,
    S_BDEC  = 15'h0010,
    S_SCAN  = 15'h0020,
    S_M0    = 15'h0040,
    S_M1    = 15'h0080,
    S_M2    = 15'h0100,
    S_CRD   = 15'h0200,
    S_CCHK  = 15'h0400,
    S_WRD   = 15'h0800,
    S_WUP   = 15'h1000,
    S_CWR   = 15'h2000,
    S_RESP  = 15'h4000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   load_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign load_ok   = !out_valid_r || out_ready;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (req_t'(in_req_type))
            REQ_COUNT:  state_nxt = S_CNT;
            REQ_ENCODE: state_nxt = S_ENC;
            REQ_BUILD: begin
              cmd.bi_start = 1'b1;
              state_nxt    = S_BINIT;
            end
            default: begin
              cmd.clr   = 1'b1;
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_CNT: begin
        cmd.cnt_upd = 1'b1;
        state_nxt   = S_RESP;
      end
      S_ENC: begin
        cmd.enc_eval = 1'b1;
        state_nxt    = S_RESP;
      end
      S_BINIT: begin
        cmd.bi_step = 1'b1;
        if (sts.bi_done) begin
          state_nxt = S_BDEC;
        end
      end
      S_BDEC: begin
        if (sts.pres_zero) begin
          cmd.res_empty = 1'b1;
          state_nxt     = S_RESP;
        end else if (sts.pres_one) begin
          cmd.cd_start = 1'b1;
          state_nxt    = S_CRD;
        end else begin
          cmd.sc_start = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.sc_step = 1'b1;
        if (sts.sc_done) begin
          state_nxt = S_M0;
        end
      end
      S_M0: begin
        cmd.mg_new = 1'b1;
        state_nxt  = S_M1;
      end
      S_M1: begin
        cmd.mg_a  = 1'b1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mg_b = 1'b1;
        if (sts.pres_two) begin
          cmd.cd_start = 1'b1;
          state_nxt    = S_CRD;
        end else begin
          cmd.sc_start = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_CRD: begin
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (sts.chk_present) begin
          cmd.cd_chk = 1'b1;
          state_nxt  = S_WRD;
        end else if (sts.last_sym) begin
          cmd.res_built = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.c_next = 1'b1;
          state_nxt  = S_CRD;
        end
      end
      S_WRD: begin
        if (sts.at_root) begin
          state_nxt = S_CWR;
        end else begin
          cmd.w_rd  = 1'b1;
          state_nxt = S_WUP;
        end
      end
      S_WUP: begin
        cmd.w_up = 1'b1;
        if (sts.too_long) begin
          cmd.res_long = 1'b1;
          state_nxt    = S_RESP;
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_CWR: begin
        cmd.c_wr = 1'b1;
        if (sts.last_sym) begin
          cmd.res_built = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.c_next = 1'b1;
          state_nxt  = S_CRD;
        end
      end
      S_RESP: begin
        if (load_ok) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/huffman_table_build_encode_core.sv]
// Top level of the static Huffman table builder and encoder.
// Depends on huf_pkg, huf_if, huf_ctrl and huf_dp.
//
//  channel | direction | word contents
//  in_ch   | sink      | req_type, symbol
//  out_ch  | source    | status, code_bits, code_length
//
// A count or encode word passes through its processing state and the result state;
// a clear goes straight to the result state. A build loads the leaves, then per
// merge makes one pass over the node slots created so far and three writes,
// then checks every byte value and, for each present symbol, walks its code up
// the tree level by level before writing it to the code table.
// Reset clears the histogram valid bits at once; no clearing pass is needed.
// A result word waits in the output register; the next word is taken
// meanwhile, and the block stalls only when its new result finds that
// register still full.
module huffman_table_build_encode_core import huf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  huf_in_if.sink    in_ch,
  huf_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_fire;

  huf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  huf_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_ch.req_type),
    .in_symbol       (in_ch.symbol),
    .sts             (sts),
    .out_status      (out_ch.status),
    .out_code_bits   (out_ch.code_bits),
    .out_code_length (out_ch.code_length)
  );

  assign in_fire = in_ch.valid && in_ch.ready;

  // The block is busy on the cycle after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input taken while previous word still in progress");

  // Results only carry code bits when the status is ok.
  a_code_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != ST_OK)) |->
      ((out_ch.code_bits == '0) && (out_ch.code_length == '0)))
    else $error("code bits on a failing result");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.status <= ST_LONG))
    else $error("undefined status code");

  // A code never exceeds the length limit.
  a_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.code_length <= LEN_W'(LEN_LIMIT)))
    else $error("code length above limit");

endmodule
